// ===== rtl/core/kwms_pkg.sv =====
// kwms_pkg: shared types and constants for the k-way merge selector core.
// No dependencies; imported by kwms_list, kwms_min_sel and the top level.
package kwms_pkg;

  localparam int KEY_W          = 32;
  localparam int IDX_W          = 3;
  localparam int STATUS_W       = 2;
  localparam int NUM_LISTS_DEF  = 8;
  localparam int LIST_DEPTH_DEF = 16;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_PULL = 1'b1
  } kwms_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSH_OK   = 2'd0,
    ST_PUSH_FULL = 2'd1,
    ST_POPPED    = 2'd2,
    ST_EMPTY     = 2'd3
  } kwms_status_e;

  // Head of one list as seen by the selector.
  typedef struct packed {
    logic                    valid;
    logic signed [KEY_W-1:0] key;
  } kwms_head_t;

endpackage

// ===== rtl/core/kwms_ram.sv =====
// kwms_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module kwms_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/kwms_list.sv =====
// kwms_list: one sorted input list as a FIFO with a two-entry head cache.
// Depends on kwms_pkg and kwms_ram.
module kwms_list
  import kwms_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  logic                    pop_i,
  input  logic signed [KEY_W-1:0] key_i,
  output logic                    full_o,
  output kwms_head_t              head_o
);

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int PTR_W = $clog2(LIST_DEPTH);

  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] ram_cnt_q, ram_cnt_d;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic             inflight_q;
  logic [1:0]       out_cnt_q, out_cnt_d;
  logic [KEY_W-1:0] head0_q, head0_d;
  logic [KEY_W-1:0] head1_q, head1_d;

  logic             push_ok;
  logic             bypass;
  logic             ram_we;
  logic             issue;
  logic             append_en;
  logic [KEY_W-1:0] append_key;
  logic [1:0]       cnt_a;
  logic [KEY_W-1:0] rd_data;

  assign full_o     = (fill_q == CNT_W'(LIST_DEPTH));
  assign head_o     = '{valid: (out_cnt_q != 2'd0), key: head0_q};
  assign push_ok    = push_i && !full_o;

  always_comb begin
    // Drop the head on a pop, then append an arriving RAM word or a bypassed key.
    cnt_a      = out_cnt_q - {1'b0, pop_i};
    head0_d    = pop_i ? head1_q : head0_q;
    head1_d    = head1_q;
    bypass     = push_ok && (ram_cnt_q == '0) && !inflight_q && (cnt_a < 2'd2);
    append_en  = inflight_q || bypass;
    append_key = inflight_q ? rd_data : key_i;
    if (append_en) begin
      if (cnt_a == 2'd0) begin
        head0_d = append_key;
      end else begin
        head1_d = append_key;
      end
    end
    out_cnt_d = cnt_a + {1'b0, append_en};

    ram_we    = push_ok && !bypass;
    issue     = (ram_cnt_q != '0) && (out_cnt_d < 2'd2);
    ram_cnt_d = ram_cnt_q + CNT_W'(ram_we) - CNT_W'(issue);
    fill_d    = fill_q + CNT_W'(push_ok) - CNT_W'(pop_i);

    wr_ptr_d = wr_ptr_q;
    if (ram_we) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(LIST_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    rd_ptr_d = rd_ptr_q;
    if (issue) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(LIST_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      ram_cnt_q  <= '0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      inflight_q <= 1'b0;
      out_cnt_q  <= 2'd0;
    end else begin
      fill_q     <= fill_d;
      ram_cnt_q  <= ram_cnt_d;
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      inflight_q <= issue;
      out_cnt_q  <= out_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head0_q <= head0_d;
    head1_q <= head1_d;
  end

  kwms_ram #(
    .DATA_W (KEY_W),
    .DEPTH  (LIST_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (key_i),
    .re_i    (issue),
    .raddr_i (rd_ptr_q),
    .rdata_o (rd_data)
  );

endmodule

// ===== rtl/core/kwms_min_sel.sv =====
// kwms_min_sel: comparator tree that picks the smallest valid head key.
// Depends on kwms_pkg. Ties go to the lower list number.
module kwms_min_sel
  import kwms_pkg::*;
#(
  parameter int NUM_LISTS = NUM_LISTS_DEF
) (
  input  kwms_head_t                       heads_i [NUM_LISTS],
  output logic                             found_o,
  output logic [$clog2(NUM_LISTS)-1:0]     idx_o,
  output logic signed [KEY_W-1:0]          key_o
);

  localparam int LVL    = $clog2(NUM_LISTS);
  localparam int LIST_W = LVL;
  localparam int P      = 1 << LVL;

  logic                    node_v [LVL+1][P];
  logic signed [KEY_W-1:0] node_k [LVL+1][P];
  logic [LIST_W-1:0]       node_i [LVL+1][P];

  always_comb begin
    logic take_r;
    for (int l = 0; l <= LVL; l++) begin
      for (int i = 0; i < P; i++) begin
        node_v[l][i] = 1'b0;
        node_k[l][i] = '0;
        node_i[l][i] = '0;
      end
    end
    for (int i = 0; i < NUM_LISTS; i++) begin
      node_v[0][i] = heads_i[i].valid;
      node_k[0][i] = heads_i[i].key;
      node_i[0][i] = LIST_W'(i);
    end
    for (int l = 0; l < LVL; l++) begin
      for (int i = 0; i < P / 2; i++) begin
        if (i < (P >> (l + 1))) begin
          // Take the right side only when it is strictly smaller.
          take_r = node_v[l][2*i+1] &&
                   (!node_v[l][2*i] || (node_k[l][2*i+1] < node_k[l][2*i]));
          node_v[l+1][i] = node_v[l][2*i] || node_v[l][2*i+1];
          node_k[l+1][i] = take_r ? node_k[l][2*i+1] : node_k[l][2*i];
          node_i[l+1][i] = take_r ? node_i[l][2*i+1] : node_i[l][2*i];
        end
      end
    end
  end

  assign found_o = node_v[LVL][0];
  assign idx_o   = node_i[LVL][0];
  assign key_o   = node_k[LVL][0];

endmodule

// ===== rtl/core/k_way_merge_selector_core.sv =====
// k_way_merge_selector_core: k-way merge of sorted lists, top level.
// Depends on kwms_pkg, kwms_list, kwms_min_sel and kwms_ram.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+--------------------------------
//   in      | input     | in_valid_i/in_stall_o | cmd_i, list_index_i, key_in_i
//   out     | output    | out_valid_o/out_stall_i | status_o, key_out_o, source_list_o
//
// Every transaction passes an input register and then a result register; one
// transaction is taken every cycle while the output does not stall.
// The rate is set by the single comparator tree over the cached list heads;
// each list keeps its two oldest keys in flops so back-to-back pops need no
// RAM read in the same cycle. Reset empties all lists at once (no clear pass).
// A stall on the output holds the result register and, once the input register
// is also full, raises in_stall_o.
module k_way_merge_selector_core
  import kwms_pkg::*;
#(
  parameter int NUM_LISTS  = NUM_LISTS_DEF,
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       cmd_i,
  input  logic [IDX_W-1:0]           list_index_i,
  input  logic signed [KEY_W-1:0]    key_in_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [STATUS_W-1:0]        status_o,
  output logic signed [KEY_W-1:0]    key_out_o,
  output logic [IDX_W-1:0]           source_list_o
);

  localparam int LIST_W = $clog2(NUM_LISTS);

  // Input register.
  logic                    in_valid_q;
  logic                    cmd_q;
  logic [IDX_W-1:0]        idx_q;
  logic signed [KEY_W-1:0] key_q;

  // Result register.
  logic                    out_valid_q;
  logic [STATUS_W-1:0]     status_q, status_d;
  logic signed [KEY_W-1:0] key_out_q, key_out_d;
  logic [IDX_W-1:0]        src_q, src_d;

  logic                    advance;
  logic                    is_push;
  logic                    is_pull;
  logic [NUM_LISTS-1:0]    push_hit;
  logic [NUM_LISTS-1:0]    push_en;
  logic [NUM_LISTS-1:0]    pop_en;
  logic [NUM_LISTS-1:0]    full;
  kwms_head_t              heads [NUM_LISTS];
  logic                    found;
  logic [LIST_W-1:0]       best_idx;
  logic signed [KEY_W-1:0] best_key;

  // Advance the held transaction when the result register is free or draining.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign is_push    = advance && (cmd_q == CMD_PUSH);
  assign is_pull    = advance && (cmd_q == CMD_PULL);

  // Decode the target list; an index past the last list hits nothing and is rejected.
  always_comb begin
    for (int l = 0; l < NUM_LISTS; l++) begin
      push_hit[l] = (32'(idx_q) == l);
      push_en[l]  = is_push && push_hit[l];
      pop_en[l]   = is_pull && found && (best_idx == LIST_W'(l));
    end
  end

  for (genvar g = 0; g < NUM_LISTS; g++) begin : g_list
    kwms_list #(
      .LIST_DEPTH (LIST_DEPTH)
    ) u_list (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .push_i (push_en[g]),
      .pop_i  (pop_en[g]),
      .key_i  (key_q),
      .full_o (full[g]),
      .head_o (heads[g])
    );
  end

  kwms_min_sel #(
    .NUM_LISTS (NUM_LISTS)
  ) u_min_sel (
    .heads_i (heads),
    .found_o (found),
    .idx_o   (best_idx),
    .key_o   (best_key)
  );

  // Form the result of the transaction in the input register.
  always_comb begin
    status_d  = ST_EMPTY;
    key_out_d = '0;
    src_d     = '0;
    if (cmd_q == CMD_PUSH) begin
      status_d = (|(push_hit & ~full)) ? ST_PUSH_OK : ST_PUSH_FULL;
    end else if (found) begin
      status_d  = ST_POPPED;
      key_out_d = best_key;
      src_d     = IDX_W'(best_idx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: load on acceptance, hold while stalled.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      cmd_q <= cmd_i;
      idx_q <= list_index_i;
      key_q <= key_in_i;
    end
    if (advance) begin
      status_q  <= status_d;
      key_out_q <= key_out_d;
      src_q     <= src_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign key_out_o     = key_out_q;
  assign source_list_o = src_q;

endmodule
